// ----- hw/rtl/dstof_pkg.sv -----
// shared constants and types for the two-way ranging time-of-flight core
package dstof_pkg;

	localparam int PEER_W         = 8;
	localparam int FLIGHT_W       = 48;
	localparam int DIST_W         = 32;
	localparam int SCALE_W        = 20;
	localparam int SCALE_FRAC     = 16;
	localparam int STAMP_BITS_DEF = 40;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd307388;

	// register index codes, taken from paddr[2]
	localparam logic REG_MM_PER_TICK = 1'b0;

	typedef struct packed {
		logic              valid;
		logic              bad;
		logic              neg;
		logic [PEER_W-1:0] peer;
	} ctl_t;

endpackage

// ----- hw/rtl/ds_twr_time_of_flight_core.sv -----
// top level of the double-sided two-way ranging time-of-flight core
// Takes the six timestamps of one ranging exchange and returns the time of flight
// (Ra*Rb - Da*Db)/(Ra+Rb+Da+Db) in timer ticks with FRAC_BITS fraction bits, and the
// distance in millimetres from the mm_per_tick_q16 register. Intervals wrap modulo the
// timer width. A zero timestamp or zero denominator gives range_valid low with zero
// values. The datapath is fully pipelined: one item per clock sustained while results
// are taken (4 front stages, 1 overflow check, 48 divider stages, one per quotient bit,
// and 3 scaling and output stages). The whole pipe advances when the output register
// is empty or being taken, so an item enters while older ones are in flight. Write
// the register only while the pipe is empty.
module ds_twr_time_of_flight_core #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF,
	parameter int FRAC_BITS  = dstof_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input item stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// peer_index[7:0], ts_first_tx, ts_first_rx, ts_reply_tx, ts_reply_rx,
	// ts_final_tx, ts_final_rx (STAMP_BITS each), zero padded to bytes
	input  logic [((8+6*STAMP_BITS+7)/8)*8-1:0]    s_tdata,
	// result item stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// peer_out[7:0], flight_ticks_q8[55:8], distance_mm[87:56]
	output logic [87:0]                            m_tdata,
	// range_valid
	output logic                                   m_tuser,
	// register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [dstof_pkg::ADDR_W-1:0]           paddr,
	input  logic [dstof_pkg::DATA_W-1:0]           pwdata,
	output logic [dstof_pkg::DATA_W-1:0]           prdata,
	output logic                                   pready
);
	import dstof_pkg::*;

	localparam int SB = STAMP_BITS;
	localparam int PO = PEER_W;

	logic adv;
	logic [SCALE_W-1:0] scale_q;

	ctl_t ctl_f, ctl_d;
	logic [2*SB-1:0] num_f;
	logic [SB+1:0] den_f;
	logic ovf_d;
	logic [FLIGHT_W-1:0] quo_d;

	logic range_valid;
	logic [PEER_W-1:0] peer_out;
	logic [FLIGHT_W-1:0] flight;
	logic [DIST_W-1:0] dist_mm;

	// the pipe moves as one; it holds only when a finished result is not taken
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// register port, single register at index zero
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MM_PER_TICK) ? DATA_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == REG_MM_PER_TICK)) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	dstof_front #(
		.STAMP_BITS(STAMP_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.peer     (s_tdata[PO-1:0]),
		.t0       (s_tdata[PO+1*SB-1:PO+0*SB]),
		.t1       (s_tdata[PO+2*SB-1:PO+1*SB]),
		.t2       (s_tdata[PO+3*SB-1:PO+2*SB]),
		.t3       (s_tdata[PO+4*SB-1:PO+3*SB]),
		.t4       (s_tdata[PO+5*SB-1:PO+4*SB]),
		.t5       (s_tdata[PO+6*SB-1:PO+5*SB]),
		.ctl_s4   (ctl_f),
		.num_s4   (num_f),
		.den_s4   (den_f)
	);

	dstof_div #(
		.STAMP_BITS(STAMP_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_f),
		.num_in  (num_f),
		.den_in  (den_f),
		.ctl_out (ctl_d),
		.ovf_out (ovf_d),
		.quo_out (quo_d)
	);

	dstof_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_in      (ctl_d),
		.ovf_in      (ovf_d),
		.quo_in      (quo_d),
		.scale       (scale_q),
		.out_valid   (m_tvalid),
		.range_valid (range_valid),
		.peer_out    (peer_out),
		.flight      (flight),
		.dist_mm     (dist_mm)
	);

	assign m_tdata = {dist_mm, flight, peer_out};
	assign m_tuser = range_valid;

endmodule

// ----- hw/rtl/dstof_front.sv -----
// front stages: intervals, denominator and partial products, products, signed numerator
module dstof_front #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [dstof_pkg::PEER_W-1:0]  peer,
	input  logic [STAMP_BITS-1:0]         t0,
	input  logic [STAMP_BITS-1:0]         t1,
	input  logic [STAMP_BITS-1:0]         t2,
	input  logic [STAMP_BITS-1:0]         t3,
	input  logic [STAMP_BITS-1:0]         t4,
	input  logic [STAMP_BITS-1:0]         t5,
	output dstof_pkg::ctl_t               ctl_s4,
	output logic [2*STAMP_BITS-1:0]       num_s4,
	output logic [STAMP_BITS+1:0]         den_s4
);
	import dstof_pkg::*;

	localparam int LO_W = STAMP_BITS / 2;
	localparam int HI_W = STAMP_BITS - LO_W;
	localparam int PW   = 2 * STAMP_BITS;
	localparam int DW   = STAMP_BITS + 2;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	ctl_t ctl_c2, ctl_c4;
	logic [STAMP_BITS-1:0] ra_s1, rb_s1, da_s1, db_s1;
	logic [DW-1:0] den_c, den_s2, den_s3;
	logic [HI_W-1:0] ra_l, ra_h, rb_l, rb_h, da_l, da_h, db_l, db_h;
	logic [2*HI_W-1:0] pll_s2, plh_s2, phl_s2, phh_s2;
	logic [2*HI_W-1:0] qll_s2, qlh_s2, qhl_s2, qhh_s2;
	logic [PW-1:0] p_s3, q_s3;
	logic p_ge;

	// stage 1: intervals modulo the timer width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.bad   <= (t0 == '0) || (t1 == '0) || (t2 == '0) ||
			                (t3 == '0) || (t4 == '0) || (t5 == '0);
			ctl_s1.neg   <= 1'b0;
			ctl_s1.peer  <= peer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s1 <= t3 - t0;
			rb_s1 <= t5 - t2;
			da_s1 <= t2 - t1;
			db_s1 <= t4 - t3;
		end
	end

	// stage 2: denominator and half-width partial products
	assign den_c = DW'(ra_s1) + DW'(rb_s1) + DW'(da_s1) + DW'(db_s1);
	assign ra_l  = HI_W'(ra_s1[LO_W-1:0]);
	assign ra_h  = HI_W'(ra_s1[STAMP_BITS-1:LO_W]);
	assign rb_l  = HI_W'(rb_s1[LO_W-1:0]);
	assign rb_h  = HI_W'(rb_s1[STAMP_BITS-1:LO_W]);
	assign da_l  = HI_W'(da_s1[LO_W-1:0]);
	assign da_h  = HI_W'(da_s1[STAMP_BITS-1:LO_W]);
	assign db_l  = HI_W'(db_s1[LO_W-1:0]);
	assign db_h  = HI_W'(db_s1[STAMP_BITS-1:LO_W]);

	always_comb begin
		ctl_c2     = ctl_s1;
		ctl_c2.bad = ctl_s1.bad || (den_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s2 <= den_c;
			pll_s2 <= ra_l * rb_l;
			plh_s2 <= ra_l * rb_h;
			phl_s2 <= ra_h * rb_l;
			phh_s2 <= ra_h * rb_h;
			qll_s2 <= da_l * db_l;
			qlh_s2 <= da_l * db_h;
			qhl_s2 <= da_h * db_l;
			qhh_s2 <= da_h * db_h;
		end
	end

	// stage 3: assemble full products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s3 <= den_s2;
			p_s3   <= PW'(pll_s2) + ((PW'(plh_s2) + PW'(phl_s2)) << LO_W) +
			          (PW'(phh_s2) << (2 * LO_W));
			q_s3   <= PW'(qll_s2) + ((PW'(qlh_s2) + PW'(qhl_s2)) << LO_W) +
			          (PW'(qhh_s2) << (2 * LO_W));
		end
	end

	// stage 4: magnitude and sign of the numerator
	assign p_ge = (p_s3 >= q_s3);

	always_comb begin
		ctl_c4     = ctl_s3;
		ctl_c4.neg = !p_ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= den_s3;
			num_s4 <= p_ge ? (p_s3 - q_s3) : (q_s3 - p_s3);
		end
	end

endmodule

// ----- hw/rtl/dstof_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow check
module dstof_div #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF,
	parameter int FRAC_BITS  = dstof_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  dstof_pkg::ctl_t                 ctl_in,
	input  logic [2*STAMP_BITS-1:0]         num_in,
	input  logic [STAMP_BITS+1:0]           den_in,
	output dstof_pkg::ctl_t                 ctl_out,
	output logic                            ovf_out,
	output logic [dstof_pkg::FLIGHT_W-1:0]  quo_out
);
	import dstof_pkg::*;

	localparam int NW = 2 * STAMP_BITS + FRAC_BITS;
	localparam int DW = STAMP_BITS + 2;
	localparam int QB = FLIGHT_W;

	logic [NW-1:0] numf, num_hi;

	ctl_t              ctl_sk [0:QB];
	logic              ovf_sk [0:QB];
	logic [DW-1:0]     rem_sk [0:QB];
	logic [DW-1:0]     den_sk [0:QB];
	logic [QB-1:0]     lo_sk  [0:QB];
	logic [QB-1:0]     quo_sk [0:QB];

	assign numf   = NW'(num_in) << FRAC_BITS;
	assign num_hi = numf >> QB;

	// entry stage: a quotient of 2^48 or more only saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sk[0] <= '0;
		end else if (adv) begin
			ctl_sk[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ovf_sk[0] <= (num_hi >= NW'(den_in));
			rem_sk[0] <= num_hi[DW-1:0];
			den_sk[0] <= den_in;
			lo_sk[0]  <= numf[QB-1:0];
			quo_sk[0] <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW:0] trial, diff;
		logic        take;

		assign trial = {rem_sk[k], lo_sk[k][QB-1]};
		assign take  = (trial >= {1'b0, den_sk[k]});
		assign diff  = take ? (trial - {1'b0, den_sk[k]}) : trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[k+1] <= '0;
			end else if (adv) begin
				ctl_sk[k+1] <= ctl_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ovf_sk[k+1] <= ovf_sk[k];
				rem_sk[k+1] <= diff[DW-1:0];
				den_sk[k+1] <= den_sk[k];
				lo_sk[k+1]  <= lo_sk[k] << 1;
				quo_sk[k+1] <= {quo_sk[k][QB-2:0], take};
			end
		end
	end

	assign ctl_out = ctl_sk[QB];
	assign ovf_out = ovf_sk[QB];
	assign quo_out = quo_sk[QB];

endmodule

// ----- hw/rtl/dstof_scale.sv -----
// saturation of the flight time, scaling to millimetres and output register
module dstof_scale #(
	parameter int FRAC_BITS = dstof_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  dstof_pkg::ctl_t                 ctl_in,
	input  logic                            ovf_in,
	input  logic [dstof_pkg::FLIGHT_W-1:0]  quo_in,
	input  logic [dstof_pkg::SCALE_W-1:0]   scale,
	output logic                            out_valid,
	output logic                            range_valid,
	output logic [dstof_pkg::PEER_W-1:0]    peer_out,
	output logic [dstof_pkg::FLIGHT_W-1:0]  flight,
	output logic [dstof_pkg::DIST_W-1:0]    dist_mm
);
	import dstof_pkg::*;

	localparam int PRW = FLIGHT_W + SCALE_W;
	localparam logic [FLIGHT_W-1:0] POS_LIM = {1'b0, {(FLIGHT_W-1){1'b1}}};
	localparam logic [FLIGHT_W-1:0] NEG_LIM = {1'b1, {(FLIGHT_W-1){1'b0}}};
	localparam logic [PRW-1:0] DPOS_LIM = PRW'({1'b0, {(DIST_W-1){1'b1}}});
	localparam logic [PRW-1:0] DNEG_LIM = PRW'({1'b1, {(DIST_W-1){1'b0}}});

	ctl_t ctl_sa, ctl_sb;
	logic [FLIGHT_W-1:0] lim, mag_c, mag_sa, flight_sa, flight_sb;
	logic [PRW-1:0] prod_sb, dmag;
	logic [DIST_W-1:0] dclip;

	assign lim   = ctl_in.neg ? NEG_LIM : POS_LIM;
	assign mag_c = ctl_in.bad ? '0 :
	               (ovf_in || (quo_in > lim)) ? lim : quo_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sa <= '0;
			ctl_sb <= '0;
		end else if (adv) begin
			ctl_sa <= ctl_in;
			ctl_sb <= ctl_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_sa    <= mag_c;
			flight_sa <= ctl_in.neg ? (FLIGHT_W'(0) - mag_c) : mag_c;
			prod_sb   <= PRW'(mag_sa) * PRW'(scale);
			flight_sb <= flight_sa;
		end
	end

	assign dmag  = prod_sb >> (FRAC_BITS + SCALE_FRAC);
	assign dclip = ctl_sb.neg ? ((dmag > DNEG_LIM) ? DNEG_LIM[DIST_W-1:0] : dmag[DIST_W-1:0])
	                          : ((dmag > DPOS_LIM) ? DPOS_LIM[DIST_W-1:0] : dmag[DIST_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_sb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			range_valid <= !ctl_sb.bad;
			peer_out    <= ctl_sb.peer;
			flight      <= flight_sb;
			dist_mm     <= ctl_sb.neg ? (DIST_W'(0) - dclip) : dclip;
		end
	end

endmodule
